FILE: rtl/ifd_pkg.sv
// ifd_pkg: shared types and constants of the frequency discriminator
// widths of samples, cross products, cordic datapath and the atan table
// no dependencies
package ifd_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int PROD_W      = 2 * SAMPLE_BITS;
   localparam int XY_W        = PROD_W + 3;
   localparam int TURN_BITS   = 32;
   localparam int Z_W         = TURN_BITS + 2;
   localparam int RATE_W      = 24;
   localparam int FREQ_W      = 24;
   localparam int MAX_STAGES  = 32;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [FREQ_W-1:0]      freq_type;
   typedef logic [RATE_W-1:0]             rate_type;

   localparam rate_type RATE_RESET = 24'd48000;

   typedef struct packed {
      logic                   valid;
      logic                   zero;
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
   } cell_type;

   localparam logic signed [Z_W-1:0] HALF_TURN = {2'b00, 1'b1, {(TURN_BITS-1){1'b0}}};

   // atan(2^-i) in units of 2^-32 turn
   localparam logic [TURN_BITS-1:0] ATAN_TURN [MAX_STAGES] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
   };

endpackage

FILE: rtl/ifd_channels.sv
// ifd_channels: valid/ready channel interfaces for samples and results
// depends on ifd_pkg
interface ifd_req_if;
   logic                valid;
   logic                ready;
   ifd_pkg::sample_type sample_real;
   ifd_pkg::sample_type sample_imag;
   logic                start_block;

   modport source (output valid, sample_real, sample_imag, start_block, input ready);
   modport sink (input valid, sample_real, sample_imag, start_block, output ready);
endinterface

interface ifd_rsp_if;
   logic              valid;
   logic              ready;
   ifd_pkg::freq_type frequency_hz;

   modport source (output valid, frequency_hz, input ready);
   modport sink (input valid, frequency_hz, output ready);
endinterface

FILE: rtl/ifd_cross_product.sv
// ifd_cross_product: keeps the previous sample, forms curr * conj(prev)
// and pre-rotates the product into the right half plane; depends on ifd_pkg
module ifd_cross_product (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                take,
   input  ifd_pkg::sample_type sample_real,
   input  ifd_pkg::sample_type sample_imag,
   input  logic                start_block,
   output ifd_pkg::cell_type   cell_out
);
   import ifd_pkg::*;

   sample_type               prev_real_ff, prev_imag_ff;
   logic                     prev_valid_ff;
   logic                     prod_valid_ff, prod_valid_in;
   logic signed [PROD_W-1:0] rr_ff, ii_ff, ir_ff, ri_ff;
   logic signed [PROD_W-1:0] rr_in, ii_in, ir_in, ri_in;
   logic signed [XY_W-1:0]   x_sum, y_diff;
   cell_type                 cell_ff, cell_in;

   assign prod_valid_in = take && !start_block && prev_valid_ff;
   assign rr_in = sample_real * prev_real_ff;
   assign ii_in = sample_imag * prev_imag_ff;
   assign ir_in = sample_imag * prev_real_ff;
   assign ri_in = sample_real * prev_imag_ff;

   assign x_sum  = XY_W'(rr_ff) + XY_W'(ii_ff);
   assign y_diff = XY_W'(ir_ff) - XY_W'(ri_ff);

   always_comb begin
      cell_in.valid = prod_valid_ff;
      cell_in.zero  = (x_sum == '0) && (y_diff == '0);
      if (x_sum < 0) begin
         cell_in.x = -x_sum;
         cell_in.y = -y_diff;
         cell_in.z = (y_diff >= 0) ? HALF_TURN : -HALF_TURN;
      end else begin
         cell_in.x = x_sum;
         cell_in.y = y_diff;
         cell_in.z = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_valid_ff <= 1'b0;
         prod_valid_ff <= 1'b0;
         cell_ff       <= '0;
      end else begin
         if (take) begin
            prev_valid_ff <= 1'b1;
         end
         if (advance) begin
            prod_valid_ff <= prod_valid_in;
            cell_ff       <= cell_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         prev_real_ff <= sample_real;
         prev_imag_ff <= sample_imag;
      end
      if (advance) begin
         rr_ff <= rr_in;
         ii_ff <= ii_in;
         ir_ff <= ir_in;
         ri_ff <= ri_in;
      end
   end

   assign cell_out = cell_ff;

endmodule

FILE: rtl/ifd_cordic_cell.sv
// ifd_cordic_cell: one registered vectoring cordic micro-rotation
// depends on ifd_pkg
module ifd_cordic_cell #(
   parameter int STAGE = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  ifd_pkg::cell_type cell_in,
   output ifd_pkg::cell_type cell_out
);
   import ifd_pkg::*;

   logic signed [XY_W-1:0] dx, dy;
   logic signed [Z_W-1:0]  dz;
   cell_type               cell_ff, next_in;

   assign dx = cell_in.y >>> STAGE;
   assign dy = cell_in.x >>> STAGE;
   assign dz = signed'({2'b00, ATAN_TURN[STAGE]});

   always_comb begin
      next_in = cell_in;
      if (cell_in.y > 0) begin
         next_in.x = cell_in.x + dx;
         next_in.y = cell_in.y - dy;
         next_in.z = cell_in.z + dz;
      end else begin
         next_in.x = cell_in.x - dx;
         next_in.y = cell_in.y + dy;
         next_in.z = cell_in.z - dz;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff <= '0;
      end else if (advance) begin
         cell_ff <= next_in;
      end
   end

   assign cell_out = cell_ff;

endmodule

FILE: rtl/ifd_freq_scale.sv
// ifd_freq_scale: rounds the cordic angle, scales it by the sample rate,
// rounds to hz and saturates; depends on ifd_pkg
module ifd_freq_scale #(
   parameter int ANGLE_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  ifd_pkg::cell_type cell_in,
   input  ifd_pkg::rate_type sample_rate,
   output logic              valid,
   output ifd_pkg::freq_type frequency_hz
);
   import ifd_pkg::*;

   localparam int SHIFT  = TURN_BITS - ANGLE_BITS;
   localparam int ANG_W  = ANGLE_BITS + 2;
   localparam int PW     = ANG_W + RATE_W + 1;
   localparam int FMAG_W = PW - ANGLE_BITS;
   localparam logic [Z_W:0] Z_HALF = {{Z_W{1'b0}}, 1'b1} << SHIFT;
   localparam logic [PW:0]  P_HALF = {{PW{1'b0}}, 1'b1} << ANGLE_BITS;
   localparam logic [FMAG_W-1:0] POS_LIMIT = FMAG_W'(2 ** (FREQ_W - 1) - 1);
   localparam logic [FMAG_W-1:0] NEG_LIMIT = FMAG_W'(2 ** (FREQ_W - 1));

   logic [Z_W-1:0]          z_mag;
   logic [Z_W:0]            z_round;
   logic [ANG_W-1:0]        ang_mag;
   logic signed [ANG_W-1:0] ang_in, ang_ff;
   logic                    valid_a_ff, zero_a_ff;
   logic signed [RATE_W:0]  rate_s;
   logic signed [PW-1:0]    prod_in, prod_ff;
   logic                    valid_p_ff, zero_p_ff;
   logic [PW-1:0]           p_mag;
   logic [PW:0]             p_round;
   logic [FMAG_W-1:0]       f_mag;
   logic                    p_neg;

   // angle rounded half away from zero to ANGLE_BITS per turn
   assign z_mag   = (cell_in.z < 0) ? Z_W'(-cell_in.z) : Z_W'(cell_in.z);
   assign z_round = ({z_mag, 1'b0} + Z_HALF) >> (SHIFT + 1);
   assign ang_mag = ANG_W'(z_round);
   assign ang_in  = (cell_in.z < 0) ? -signed'(ang_mag) : signed'(ang_mag);

   assign rate_s  = signed'({1'b0, sample_rate});
   assign prod_in = ang_ff * rate_s;

   // product rounded half away from zero, then clamped to the output range
   assign p_neg   = prod_ff < 0;
   assign p_mag   = p_neg ? PW'(-prod_ff) : PW'(prod_ff);
   assign p_round = ({p_mag, 1'b0} + P_HALF) >> (ANGLE_BITS + 1);
   assign f_mag   = FMAG_W'(p_round);

   always_comb begin
      if (zero_p_ff) begin
         frequency_hz = '0;
      end else if (p_neg) begin
         frequency_hz = (f_mag > NEG_LIMIT) ? freq_type'(-NEG_LIMIT)
                                            : -signed'(FREQ_W'(f_mag));
      end else begin
         frequency_hz = (f_mag > POS_LIMIT) ? signed'(FREQ_W'(POS_LIMIT))
                                            : signed'(FREQ_W'(f_mag));
      end
   end

   assign valid = valid_p_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_p_ff <= 1'b0;
      end else if (advance) begin
         valid_a_ff <= cell_in.valid;
         valid_p_ff <= valid_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         zero_a_ff <= cell_in.zero;
         ang_ff    <= ang_in;
         zero_p_ff <= zero_a_ff;
         prod_ff   <= prod_in;
      end
   end

endmodule

FILE: rtl/instantaneous_frequency_discriminator.sv
// instantaneous_frequency_discriminator: top level of the fm discriminator
// depends on ifd_pkg, ifd_channels, ifd_cross_product, ifd_cordic_cell,
// ifd_freq_scale
//
// usage:
//   req_ch carries one complex sample per transfer; a sample with
//   start_block set, or the first after reset, is only stored as previous
//   and gives no result. every other sample gives one transfer on rsp_ch
//   with the frequency of the phase step from the previous sample, in hz.
//   csr_wr_en/csr_wr_data write the sample rate (reset 48000); write it
//   only while the pipeline is empty.
//   from its sample transfer a result passes two cross product stages,
//   one register per cordic cell, angle rounding and rate multiply
//   stages and an output register before it is valid on rsp_ch.
//   throughput: one sample per cycle unless stalled; the cordic cells
//   form a pipeline. when rsp_ch stalls with a result waiting, the whole
//   pipeline holds and req_ch.ready drops; it rises again in the cycle
//   the result is taken. reset clears the previous-sample flag and all
//   stage valids, and sets the rate back to 48000.
module instantaneous_frequency_discriminator #(
   parameter int ANGLE_BITS    = 16,
   parameter int CORDIC_STAGES = 16
) (
   input  logic              clock,
   input  logic              reset,
   ifd_req_if.sink           req_ch,
   ifd_rsp_if.source         rsp_ch,
   input  logic              csr_wr_en,
   input  ifd_pkg::rate_type csr_wr_data
);
   import ifd_pkg::*;

   rate_type sample_rate_ff;
   logic     advance, take;
   cell_type chain [CORDIC_STAGES+1];
   logic     scale_valid;
   freq_type scale_freq;
   logic     rsp_valid_ff;
   freq_type rsp_freq_ff;

   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign take         = req_ch.valid && advance;
   assign req_ch.ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_rate_ff <= RATE_RESET;
      end else if (csr_wr_en) begin
         sample_rate_ff <= csr_wr_data;
      end
   end

   ifd_cross_product u_cross (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .take        (take),
      .sample_real (req_ch.sample_real),
      .sample_imag (req_ch.sample_imag),
      .start_block (req_ch.start_block),
      .cell_out    (chain[0])
   );

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
      ifd_cordic_cell #(
         .STAGE (i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .cell_in  (chain[i]),
         .cell_out (chain[i+1])
      );
   end

   ifd_freq_scale #(
      .ANGLE_BITS (ANGLE_BITS)
   ) u_scale (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .cell_in      (chain[CORDIC_STAGES]),
      .sample_rate  (sample_rate_ff),
      .valid        (scale_valid),
      .frequency_hz (scale_freq)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= scale_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_freq_ff <= scale_freq;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.frequency_hz = rsp_freq_ff;

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// testbench: checks the frequency discriminator against a phase-step predictor
// drives samples on req_ch, checks frequencies on rsp_ch, writes the sample rate
// depends on ifd_pkg, ifd_channels and instantaneous_frequency_discriminator
module testbench;
   import ifd_pkg::*;

   localparam int ANGLE_BITS    = 16;
   localparam int CORDIC_STAGES = 16;
   localparam int LATENCY       = CORDIC_STAGES + 4;
   localparam int DRAIN_CYCLES  = LATENCY + 12;
   localparam int QUIET_LIMIT   = 2000;
   localparam int LONG_HOLD     = 250;
   localparam real PI           = 3.14159265358979;

   // atan(2^-i) in 2^-32 turn units
   localparam longint ATAN_STEP [16] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
      64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
      64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
      64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D
   };

   class phase_step_predictor;
      rate_type rate;
      longint   prev_real;
      longint   prev_imag;
      bit       prev_valid;
      freq_type expected_hz[$];
      int       failures;

      function new();
         rate       = RATE_RESET;
         prev_real  = 0;
         prev_imag  = 0;
         prev_valid = 1'b0;
         failures   = 0;
      endfunction

      function longint round_away(longint v, int s);
         longint mag;
         mag = (v < 0) ? -v : v;
         mag = (mag + (longint'(1) << (s - 1))) >>> s;
         return (v < 0) ? -mag : mag;
      endfunction

      function longint turn_angle(longint x_in, longint y_in);
         longint x, y, z, dx, dy;
         int     i;
         x = x_in;
         y = y_in;
         z = 0;
         if (x < 0) begin
            z = (y >= 0) ? (longint'(1) << 31) : -(longint'(1) << 31);
            x = -x;
            y = -y;
         end
         for (i = 0; i < CORDIC_STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
               x = x + dx;
               y = y - dy;
               z = z + ATAN_STEP[i];
            end else begin
               x = x - dx;
               y = y + dy;
               z = z - ATAN_STEP[i];
            end
         end
         return z;
      endfunction

      function freq_type phase_step_hz(longint cr, longint ci);
         longint x, y, ang, f;
         x = cr * prev_real + ci * prev_imag;
         y = ci * prev_real - cr * prev_imag;
         if (x == 0 && y == 0) return '0;
         ang = round_away(turn_angle(x, y), 32 - ANGLE_BITS);
         f = round_away(ang * longint'(rate), ANGLE_BITS);
         if (f > 8388607) f = 8388607;
         if (f < -8388608) f = -8388608;
         return freq_type'(f);
      endfunction

      function void note_sample(sample_type re, sample_type im, logic start);
         longint cr, ci;
         cr = re;
         ci = im;
         if (!start && prev_valid) expected_hz.push_back(phase_step_hz(cr, ci));
         prev_real  = cr;
         prev_imag  = ci;
         prev_valid = 1'b1;
      endfunction

      function void check_frequency(freq_type got);
         freq_type want;
         if (expected_hz.size() == 0) begin
            failures++;
            $display("%0t: frequency_hz expected none, actual %0d", $time, got);
            return;
         end
         want = expected_hz.pop_front();
         if (got !== want) begin
            failures++;
            $display("%0t: frequency_hz expected %0d, actual %0d", $time, want, got);
         end
      endfunction

      function void close_out();
         if (expected_hz.size() != 0) begin
            failures += expected_hz.size();
            $display("%0t: %0d frequency results expected, actual none", $time,
                     expected_hz.size());
         end
      endfunction
   endclass

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     csr_wr_en;
   rate_type csr_wr_data;
   int       quiet_cycles = 0;
   int       req_span = 0;
   bit       req_calm = 1'b0;
   int       rsp_span = 0;
   bit       rsp_calm = 1'b0;

   phase_step_predictor hz_predictor = new();

   ifd_req_if req_ch();
   ifd_rsp_if rsp_ch();

   instantaneous_frequency_discriminator #(
      .ANGLE_BITS    (ANGLE_BITS),
      .CORDIC_STAGES (CORDIC_STAGES)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // transfer monitors
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         hz_predictor.note_sample(req_ch.sample_real, req_ch.sample_imag, req_ch.start_block);
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         hz_predictor.check_frequency(rsp_ch.frequency_hz);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("instantaneous_frequency_discriminator verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // idle cycles before the next transfer, with stretches of none
   function automatic int idle_draw(inout int span, inout bit calm);
      if (span == 0) begin
         calm = ($urandom_range(0, 2) == 0);
         span = $urandom_range(8, 60);
      end
      span--;
      return calm ? 0 : $urandom_range(0, 14);
   endfunction

   function automatic sample_type edge_value();
      case ($urandom_range(0, 6))
         0: return -32768;
         1: return -32767;
         2: return -1;
         3: return 0;
         4: return 1;
         5: return 32766;
         default: return 32767;
      endcase
   endfunction

   task automatic send_sample(input sample_type re, input sample_type im, input logic start);
      int gap;
      gap = idle_draw(req_span, req_calm);
      if (gap > 0) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid       <= 1'b1;
      req_ch.sample_real <= re;
      req_ch.sample_imag <= im;
      req_ch.start_block <= start;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic send_tone(input int len);
      real amp, step, ph;
      int  k;
      if ($urandom_range(0, 3) == 0) amp = $urandom_range(1, 60);
      else amp = $urandom_range(1000, 32767);
      step = (real'($urandom_range(0, 2000)) - 1000.0) * PI / 1000.0;
      ph = real'($urandom_range(0, 6283)) / 1000.0;
      for (k = 0; k < len; k++) begin
         send_sample(sample_type'($rtoi(amp * $cos(ph))), sample_type'($rtoi(amp * $sin(ph))),
                     (k == 0) ? ($urandom_range(0, 1) == 1) : ($urandom_range(0, 19) == 0));
         ph = ph + step;
      end
   endtask

   task automatic random_samples(input int n);
      int done, len, kind;
      done = 0;
      while (done < n) begin
         kind = $urandom_range(0, 99);
         if (kind < 60) begin
            len = $urandom_range(4, 24);
            send_tone(len);
            done += len;
         end else if (kind < 85) begin
            send_sample(sample_type'($urandom), sample_type'($urandom), $urandom_range(0, 7) == 0);
            done++;
         end else begin
            send_sample(edge_value(), edge_value(), $urandom_range(0, 5) == 0);
            done++;
         end
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (hz_predictor.expected_hz.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_rate(input rate_type r);
      drain();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= r;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      hz_predictor.rate = r;
   endtask

   // result side, with a long hold-off twice to back up the pipeline
   initial begin : result_sink
      int taken, hold;
      taken = 0;
      rsp_ch.ready = 1'b0;
      wait (!reset);
      forever begin
         if (taken == 120 || taken == 420) hold = LONG_HOLD;
         else hold = idle_draw(rsp_span, rsp_calm);
         if (hold > 0) begin
            @(negedge clock);
            rsp_ch.ready <= 1'b0;
            repeat (hold - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         taken++;
      end
   end

   initial begin
      req_ch.valid       = 1'b0;
      req_ch.sample_real = '0;
      req_ch.sample_imag = '0;
      req_ch.start_block = 1'b0;
      csr_wr_en          = 1'b0;
      csr_wr_data        = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset rate: first sample, quarter and half turns, zero products, extremes
      send_sample(1000, 0, 1'b0);
      send_sample(0, 1000, 1'b0);
      send_sample(-1000, 0, 1'b0);
      send_sample(1000, 0, 1'b0);
      send_sample(0, 0, 1'b0);
      send_sample(0, 0, 1'b0);
      send_sample(32767, 32767, 1'b0);
      send_sample(-32768, -32768, 1'b0);
      send_sample(32767, -32768, 1'b0);
      send_sample(-32768, 32767, 1'b0);
      send_sample(-1, -1, 1'b1);
      send_sample(1, 0, 1'b0);
      send_sample(1, 1, 1'b0);
      send_sample(-32768, 0, 1'b1);
      send_sample(-32768, 0, 1'b0);
      send_sample(32767, -1, 1'b0);

      // top rate: half turn saturates
      write_rate(24'hFFFFFF);
      send_sample(100, 0, 1'b0);
      send_sample(-100, 0, 1'b0);
      send_sample(0, -100, 1'b0);
      send_sample(100, 0, 1'b0);

      // rate zero
      write_rate(24'd0);
      send_sample(0, 100, 1'b0);
      send_sample(-100, 0, 1'b0);
      send_sample(100, -5, 1'b0);

      write_rate(24'd1);
      random_samples(90);
      write_rate(24'hFFFFFF);
      random_samples(110);
      write_rate(24'd0);
      random_samples(40);
      write_rate(rate_type'($urandom_range(1000, 1000000)));
      random_samples(110);
      write_rate(rate_type'($urandom_range(1, 16777215)));
      random_samples(110);
      write_rate(rate_type'($urandom_range(2, 200)));
      random_samples(80);
      write_rate(RATE_RESET);
      random_samples(110);

      drain();
      hz_predictor.close_out();
      if (hz_predictor.failures == 0) begin
         $display("instantaneous_frequency_discriminator verification clean");
      end else begin
         $display("instantaneous_frequency_discriminator verification failed");
      end
      $finish;
   end

endmodule
